/* sv/pngunf_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and the paeth predictor for the png scanline unfilter
package pngunf_pkg;

   localparam int MAX_ROW_BYTES = 4096;
   localparam int ROW_IDX_W     = $clog2(MAX_ROW_BYTES);
   localparam int BYTE_POS_W    = $clog2(MAX_ROW_BYTES + 1);
   localparam int WIDTH_W       = 16;
   localparam int DEPTH_W       = 2;
   localparam int ROW_BYTES_W   = WIDTH_W + 4;
   localparam int CNT_W         = 4;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 16;
   localparam int REQ_TDATA_W   = 8;
   localparam int RSP_TDATA_W   = 16;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH = 1'b0,
      CSR_DEPTH_CODE  = 1'b1
   } csr_index_type;

   typedef enum logic [DEPTH_W-1:0] {
      DEPTH_1 = 2'd0,
      DEPTH_2 = 2'd1,
      DEPTH_4 = 2'd2,
      DEPTH_8 = 2'd3
   } depth_type;

   // one reconstructed byte on its way to the unpacker
   typedef struct packed {
      logic [7:0]       value;
      logic [CNT_W-1:0] count;
      logic             row_last;
      logic             bad;
      depth_type        depth;
   } byte_item_type;

   typedef struct packed {
      logic [7:0] pixel_index;
      logic       row_end;
      logic       bad_filter;
      logic       last;
   } pixel_item_type;

   function automatic logic [7:0] paeth_predict(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c);
      logic signed [10:0] p;
      logic signed [10:0] da;
      logic signed [10:0] db;
      logic signed [10:0] dc;
      p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
      da = p - $signed({3'b000, a});
      db = p - $signed({3'b000, b});
      dc = p - $signed({3'b000, c});
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return a;
      return (db <= dc) ? b : c;
   endfunction

endpackage

/* sv/png_scanline_unfilter_unpack.sv */
`timescale 1ns / 1ps
// top level: png scanline filter reversal and palette index unpacking
// Takes the inflated image stream one byte per request: each row is a filter type byte
// followed by the row's packed bytes, and image_start on a byte restarts the image. Each
// data byte is reconstructed (none, sub, up, average, paeth) and split msb-first into
// 8 >> depth_code palette indices, fewer at the end of a row, one response per pixel, those
// of a byte in successive cycles while rsp_tready is high. The unpacker sets the pace: it
// holds a data byte until all its pixels have left; a filter byte gives no response. The
// first response passes the input register, the unpacker byte and the response register.
// The upper row sits in a 4096 x 8 memory read one byte ahead; it needs no clearing
// after reset, as the first row of an image takes it as zero. A filter byte above 4
// gives one response with bad_filter set, and bytes are then dropped until image_start.
// Configuration is taken at any time but is meant to change only while the block is idle.
module png_scanline_unfilter_unpack (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pngunf_pkg::REQ_TDATA_W-1:0]   req_tdata,   // raw_byte
   input  logic                                 req_tuser,   // image_start
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pngunf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // pixel_index, last, zero fill
   output logic                                 rsp_tlast,   // row_end
   output logic                                 rsp_tuser,   // bad_filter
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pngunf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pngunf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pngunf_pkg::*;

   logic [WIDTH_W-1:0] image_width_ff;
   depth_type          depth_code_ff;

   logic               bo_valid, bo_ready;
   byte_item_type      bo_item;
   pixel_item_type     rsp_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= WIDTH_W'(1);
         depth_code_ff  <= DEPTH_8;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: image_width_ff <= csr_wdata[WIDTH_W-1:0];
            CSR_DEPTH_CODE:  depth_code_ff  <= depth_type'(csr_wdata[DEPTH_W-1:0]);
            default:         image_width_ff <= image_width_ff;
         endcase
      end
   end

   pngunf_unfilter u_unfilter (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_raw      (req_tdata[7:0]),
      .in_start    (req_tuser),
      .image_width (image_width_ff),
      .depth_code  (depth_code_ff),
      .bo_valid    (bo_valid),
      .bo_ready    (bo_ready),
      .bo_item     (bo_item)
   );

   pngunf_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .bi_valid  (bo_valid),
      .bi_ready  (bo_ready),
      .bi_item   (bo_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign rsp_tdata = {(RSP_TDATA_W - 9)'(0), rsp_item.last, rsp_item.pixel_index};
   assign rsp_tlast = rsp_item.row_end;
   assign rsp_tuser = rsp_item.bad_filter;

   // error response stands alone: single, last, no row end, zero index
   a_bad_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[8] && !rsp_tlast && rsp_tdata[7:0] == 8'd0)
      else $error("bad filter response malformed");

   // a row can only end on the last pixel of a byte
   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[8])
      else $error("row end without last");

   // pixel count handed to the unpacker fits the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      bo_valid |-> bo_item.count != '0 && bo_item.count <= CNT_W'(4'd8 >> bo_item.depth))
      else $error("pixel count out of range");

   // a byte handed over with a stalled response side keeps the response pending
   a_hold_pending: assert property (@(posedge clock) disable iff (reset)
      bo_valid && bo_ready && rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("unpacker dropped pending work");

endmodule

/* sv/pngunf_unfilter.sv */
`timescale 1ns / 1ps
// input register, row state, prior row memory and filter reversal
module pngunf_unfilter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [7:0]                            in_raw,
   input  logic                                  in_start,
   input  logic [pngunf_pkg::WIDTH_W-1:0]        image_width,
   input  pngunf_pkg::depth_type                 depth_code,
   output logic                                  bo_valid,
   input  logic                                  bo_ready,
   output pngunf_pkg::byte_item_type             bo_item
);
   import pngunf_pkg::*;

   logic                  in_valid_ff;
   logic [7:0]            in_raw_ff;
   logic                  in_start_ff;

   logic [7:0]            left_ff, left_in;
   logic [7:0]            upleft_ff, upleft_in;
   logic [BYTE_POS_W-1:0] bp_ff, bp_in;
   logic [WIDTH_W-1:0]    pp_ff, pp_in;
   filter_type            fk_ff, fk_in;
   logic                  hp_ff, hp_in;
   logic                  ab_ff, ab_in;

   logic [7:0]            prior_row_ff [MAX_ROW_BYTES];
   logic [7:0]            prior_rd_ff;
   logic [ROW_IDX_W-1:0]  rd_addr;
   logic                  wr_en;

   logic [7:0]            e_left, e_upleft;
   logic [BYTE_POS_W-1:0] e_bp;
   logic [WIDTH_W-1:0]    e_pp;
   filter_type            e_fk;
   logic                  e_hp, e_ab;

   logic [WIDTH_W-1:0]     width_eff;
   logic [ROW_BYTES_W-1:0] rb_full;
   logic [BYTE_POS_W-1:0]  rb_clamp;
   logic                   row_last;
   logic                   first_byte;
   logic [ROW_IDX_W-1:0]   idx;
   logic [7:0]             a, b, c, v;
   logic [8:0]             ab_sum;
   logic [CNT_W-1:0]       per, count;
   logic [WIDTH_W-1:0]     rem;
   logic                   is_filter, bad_byte, produce, take;

   // effective state once a pending image start is applied
   always_comb begin
      if (in_start_ff) begin
         e_left   = '0;
         e_upleft = '0;
         e_bp     = '0;
         e_pp     = '0;
         e_fk     = FILT_NONE;
         e_hp     = 1'b0;
         e_ab     = 1'b0;
      end else begin
         e_left   = left_ff;
         e_upleft = upleft_ff;
         e_bp     = bp_ff;
         e_pp     = pp_ff;
         e_fk     = fk_ff;
         e_hp     = hp_ff;
         e_ab     = ab_ff;
      end
   end

   always_comb begin
      width_eff = (image_width == '0) ? WIDTH_W'(1) : image_width;
      rb_full   = ((ROW_BYTES_W'(width_eff) << depth_code) + ROW_BYTES_W'(7)) >> 3;
      rb_clamp  = (rb_full > ROW_BYTES_W'(MAX_ROW_BYTES)) ? BYTE_POS_W'(MAX_ROW_BYTES)
                                                          : rb_full[BYTE_POS_W-1:0];
      row_last   = (e_bp >= rb_clamp);
      first_byte = (e_bp == BYTE_POS_W'(1));
      idx        = ROW_IDX_W'(e_bp - BYTE_POS_W'(1));

      a = first_byte ? 8'd0 : e_left;
      b = e_hp ? prior_rd_ff : 8'd0;
      c = (e_hp && !first_byte) ? e_upleft : 8'd0;
      ab_sum = {1'b0, a} + {1'b0, b};

      case (e_fk)
         FILT_SUB:   v = in_raw_ff + a;
         FILT_UP:    v = in_raw_ff + b;
         FILT_AVG:   v = in_raw_ff + ab_sum[8:1];
         FILT_PAETH: v = in_raw_ff + paeth_predict(a, b, c);
         default:    v = in_raw_ff;
      endcase

      per   = CNT_W'(4'd8 >> depth_code);
      rem   = (width_eff > e_pp) ? (width_eff - e_pp) : '0;
      count = (rem >= WIDTH_W'(per)) ? per : ((rem != '0) ? CNT_W'(rem) : CNT_W'(1));

      is_filter = (e_bp == '0);
      bad_byte  = is_filter && (in_raw_ff > 8'(FILT_PAETH));
      produce   = !e_ab && (!is_filter || bad_byte);
      take      = in_valid_ff && (!produce || bo_ready);
   end

   assign in_ready = !in_valid_ff || take;
   assign bo_valid = in_valid_ff && produce;

   always_comb begin
      bo_item.value    = bad_byte ? 8'd0 : v;
      bo_item.count    = bad_byte ? CNT_W'(1) : count;
      bo_item.row_last = !bad_byte && row_last;
      bo_item.bad      = bad_byte;
      bo_item.depth    = depth_code;
   end

   always_comb begin
      left_in   = left_ff;
      upleft_in = upleft_ff;
      bp_in     = bp_ff;
      pp_in     = pp_ff;
      fk_in     = fk_ff;
      hp_in     = hp_ff;
      ab_in     = ab_ff;
      wr_en     = 1'b0;
      if (take) begin
         left_in   = e_left;
         upleft_in = e_upleft;
         bp_in     = e_bp;
         pp_in     = e_pp;
         fk_in     = e_fk;
         hp_in     = e_hp;
         ab_in     = e_ab;
         if (!e_ab) begin
            if (is_filter) begin
               if (bad_byte) begin
                  ab_in = 1'b1;
               end else begin
                  fk_in     = filter_type'(in_raw_ff[2:0]);
                  bp_in     = BYTE_POS_W'(1);
                  pp_in     = '0;
                  left_in   = '0;
                  upleft_in = '0;
               end
            end else begin
               wr_en     = 1'b1;
               left_in   = v;
               upleft_in = b;
               pp_in     = e_pp + WIDTH_W'(count);
               if (row_last) begin
                  bp_in     = '0;
                  pp_in     = '0;
                  left_in   = '0;
                  upleft_in = '0;
                  hp_in     = 1'b1;
               end else begin
                  bp_in = e_bp + BYTE_POS_W'(1);
               end
            end
         end
      end
      // read one byte ahead: the entry the next data byte will need
      rd_addr = (bp_in == '0) ? '0 : ROW_IDX_W'(bp_in - BYTE_POS_W'(1));
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prior_row_ff[idx] <= v;
      end
      prior_rd_ff <= prior_row_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         left_ff     <= '0;
         upleft_ff   <= '0;
         bp_ff       <= '0;
         pp_ff       <= '0;
         fk_ff       <= FILT_NONE;
         hp_ff       <= 1'b0;
         ab_ff       <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= in_valid;
         end
         left_ff   <= left_in;
         upleft_ff <= upleft_in;
         bp_ff     <= bp_in;
         pp_ff     <= pp_in;
         fk_ff     <= fk_in;
         hp_ff     <= hp_in;
         ab_ff     <= ab_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         in_raw_ff   <= in_raw;
         in_start_ff <= in_start;
      end
   end

endmodule

/* sv/pngunf_unpack.sv */
`timescale 1ns / 1ps
// msb-first pixel unpacker with the response register
module pngunf_unpack (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          bi_valid,
   output logic                          bi_ready,
   input  pngunf_pkg::byte_item_type     bi_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pngunf_pkg::pixel_item_type    rsp_item
);
   import pngunf_pkg::*;

   logic             cur_valid_ff;
   logic [7:0]       sh_ff, sh_in;
   logic [CNT_W-1:0] rem_ff;
   logic             row_last_ff;
   logic             bad_ff;
   depth_type        depth_ff;

   logic             rsp_valid_ff;
   pixel_item_type   rsp_item_ff, rsp_item_in;

   logic             out_load, emit, done;
   logic [7:0]       pixel;

   always_comb begin
      case (depth_ff)
         DEPTH_1: begin
            pixel = {7'd0, sh_ff[7]};
            sh_in = {sh_ff[6:0], 1'b0};
         end
         DEPTH_2: begin
            pixel = {6'd0, sh_ff[7:6]};
            sh_in = {sh_ff[5:0], 2'b00};
         end
         DEPTH_4: begin
            pixel = {4'd0, sh_ff[7:4]};
            sh_in = {sh_ff[3:0], 4'b0000};
         end
         default: begin
            pixel = sh_ff;
            sh_in = 8'd0;
         end
      endcase
      out_load = !rsp_valid_ff || rsp_ready;
      emit     = cur_valid_ff && out_load;
      done     = emit && (rem_ff == CNT_W'(1));
      rsp_item_in.pixel_index = pixel;
      rsp_item_in.last        = (rem_ff == CNT_W'(1));
      rsp_item_in.row_end     = row_last_ff && (rem_ff == CNT_W'(1));
      rsp_item_in.bad_filter  = bad_ff;
   end

   assign bi_ready  = !cur_valid_ff || done;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (bi_ready) begin
            cur_valid_ff <= bi_valid;
         end
         if (out_load) begin
            rsp_valid_ff <= cur_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (bi_ready && bi_valid) begin
         sh_ff       <= bi_item.value;
         rem_ff      <= bi_item.count;
         row_last_ff <= bi_item.row_last;
         bad_ff      <= bi_item.bad;
         depth_ff    <= bi_item.depth;
      end else if (emit) begin
         sh_ff  <= sh_in;
         rem_ff <= rem_ff - CNT_W'(1);
      end
      if (emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule

/* sim/png_scanline_unfilter_unpack_test.sv */
`timescale 1ns / 1ps
// testbench for png_scanline_unfilter_unpack: directed table, then random images
module png_scanline_unfilter_unpack_test;
   import pngunf_pkg::*;

   localparam int          RANDOM_ITEMS   = 100;
   localparam int          SETTLE_CYCLES  = 16;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          PRINT_LIMIT    = 40;
   localparam logic [7:0]  FILT_BAD_MIN   = 8'd5;
   localparam logic [7:0]  FILT_BAD_MAX   = 8'hFF;

   typedef enum logic {
      STEP_BYTE,
      STEP_CSR
   } step_kind_type;

   typedef struct packed {
      step_kind_type  kind;
      csr_index_type  sel;
      logic [15:0]    value;
      logic           start;
      logic           typed;
      pixel_item_type want;
   } directed_step_type;

   localparam pixel_item_type NO_PIXEL  = '0;
   localparam pixel_item_type ERR_PIXEL = '{8'h00, 1'b0, 1'b1, 1'b1};

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   req_tuser   = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   png_scanline_unfilter_unpack u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // unfilter state mirrored from the block
   logic [15:0]    cfg_width = 16'd1;
   depth_type      cfg_depth = DEPTH_8;
   logic [7:0]     upper_row [MAX_ROW_BYTES];
   bit             upper_written [MAX_ROW_BYTES];
   logic [7:0]     left_value;
   logic [7:0]     upleft_value;
   int unsigned    byte_pos;
   logic [15:0]    pixel_pos;
   filter_type     row_filter;
   bit             have_upper;
   bit             stream_aborted;

   pixel_item_type byte_pixels [$];
   pixel_item_type pixel_q [$];

   int             mismatches;
   int             n_requests;
   int             n_pixels;
   int             n_bad;
   int             n_csr_writes;
   int             burst_left;
   int             quiet_cycles;
   bit [15:0]      stall_pattern = 16'hFFFF;
   bit [15:0]      stall_step;
   directed_step_type directed_plan [32];

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
      mismatches++;
   endtask

   function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      int p;
      int pa;
      int pb;
      int pc;
      p  = int'(a) + int'(b) - int'(c);
      pa = p - int'(a);
      pb = p - int'(b);
      pc = p - int'(c);
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) return a;
      return (pb <= pc) ? b : c;
   endfunction

   function automatic int unsigned row_length(input logic [15:0] w, input depth_type d);
      int unsigned pixels;
      int unsigned len;
      pixels = (w == 0) ? 1 : w;
      len    = (pixels * (1 << d) + 7) / 8;
      return (len > MAX_ROW_BYTES) ? MAX_ROW_BYTES : len;
   endfunction

   // reconstructs one request and leaves its pixels in byte_pixels
   function automatic void unfilter_byte(input logic [7:0] raw, input logic start);
      int unsigned    pixels;
      int unsigned    bits;
      int unsigned    per;
      int unsigned    len;
      int unsigned    idx;
      int unsigned    owed;
      int unsigned    count;
      logic [7:0]     a;
      logic [7:0]     b;
      logic [7:0]     c;
      logic [7:0]     v;
      logic [8:0]     sum;
      bit             row_done;
      pixel_item_type px;
      byte_pixels.delete();
      pixels = (cfg_width == 0) ? 1 : cfg_width;
      bits   = 1 << cfg_depth;
      per    = 8 >> cfg_depth;
      len    = row_length(cfg_width, cfg_depth);
      if (start) begin
         left_value     = '0;
         upleft_value   = '0;
         byte_pos       = 0;
         pixel_pos      = '0;
         row_filter     = FILT_NONE;
         have_upper     = 1'b0;
         stream_aborted = 1'b0;
      end
      if (stream_aborted) return;
      if (byte_pos == 0) begin
         if (raw > FILT_PAETH) begin
            stream_aborted = 1'b1;
            byte_pixels.push_back(ERR_PIXEL);
            return;
         end
         row_filter   = filter_type'(raw[2:0]);
         byte_pos     = 1;
         pixel_pos    = '0;
         left_value   = '0;
         upleft_value = '0;
         return;
      end
      idx = byte_pos - 1;
      if (idx >= MAX_ROW_BYTES) idx = MAX_ROW_BYTES - 1;
      row_done = (idx + 1 >= len);
      a = (idx >= 1) ? left_value : 8'h00;
      b = have_upper ? upper_row[idx] : 8'h00;
      c = (have_upper && idx >= 1) ? upleft_value : 8'h00;
      sum = a + b;
      case (row_filter)
         FILT_SUB:   v = raw + a;
         FILT_UP:    v = raw + b;
         FILT_AVG:   v = raw + sum[8:1];
         FILT_PAETH: v = raw + paeth_pick(a, b, c);
         default:    v = raw;
      endcase
      upper_row[idx]     = v;
      upper_written[idx] = 1'b1;
      left_value         = v;
      upleft_value       = b;
      owed  = (pixels > pixel_pos) ? pixels - pixel_pos : 0;
      count = (owed >= per) ? per : ((owed != 0) ? owed : 1);
      for (int k = 0; k < count; k++) begin
         px.pixel_index = 8'((int'(v) >> (8 - bits * (k + 1))) & ((1 << bits) - 1));
         px.row_end     = row_done && (k + 1 == count);
         px.bad_filter  = 1'b0;
         px.last        = (k + 1 == count);
         byte_pixels.push_back(px);
      end
      pixel_pos = 16'(pixel_pos + count);
      if (row_done) begin
         byte_pos     = 0;
         pixel_pos    = '0;
         left_value   = '0;
         upleft_value = '0;
         have_upper   = 1'b1;
      end else begin
         byte_pos = idx + 2;
      end
   endfunction

   // true when the upper row under a new setting holds only written bytes
   function automatic bit upper_row_ready(input logic [15:0] w, input depth_type d);
      int unsigned len;
      len = row_length(w, d);
      if (!have_upper) return 1'b1;
      for (int j = 0; j < len; j++)
         if (!upper_written[j]) return 1'b0;
      if (byte_pos != 0 && !upper_written[byte_pos - 1]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] pick_filter_byte();
      if ($urandom_range(0, 19) == 0) return 8'($urandom_range(FILT_BAD_MIN, 255));
      return 8'($urandom_range(FILT_NONE, FILT_PAETH));
   endfunction

   function automatic logic [7:0] pick_data_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] raw, input logic start);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_tdata  <= raw;
      req_tuser  <= start;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      burst_left--;
      n_requests++;
      unfilter_byte(raw, start);
      foreach (byte_pixels[k]) pixel_q.push_back(byte_pixels[k]);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type sel, input logic [15:0] value);
      csr_index <= sel;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      if (sel == CSR_IMAGE_WIDTH) cfg_width = value;
      else cfg_depth = depth_type'(value[DEPTH_W-1:0]);
      n_csr_writes++;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (stall_step[6:0] == 0) begin
         case ($urandom_range(0, 3))
            0:       stall_pattern = 16'hFFFF;
            1:       stall_pattern = 16'($urandom) | 16'h0001;
            2:       stall_pattern = 16'hF0F3;
            default: stall_pattern = 16'h9249;
         endcase
      end
      rsp_tready <= stall_pattern[stall_step[3:0]];
      stall_step++;
   end

   always @(posedge clock) begin
      pixel_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_pixels++;
         if (pixel_q.size() == 0) begin
            report_mismatch("unexpected response", 0, rsp_tdata);
         end else begin
            want = pixel_q.pop_front();
            if (want.bad_filter) n_bad++;
            if (rsp_tdata[7:0] != want.pixel_index)
               report_mismatch("pixel_index", want.pixel_index, rsp_tdata[7:0]);
            if (rsp_tdata[8] != want.last) report_mismatch("last", want.last, rsp_tdata[8]);
            if (rsp_tdata[RSP_TDATA_W-1:9] != 0)
               report_mismatch("tdata fill", 0, rsp_tdata[RSP_TDATA_W-1:9]);
            if (rsp_tlast != want.row_end) report_mismatch("row_end", want.row_end, rsp_tlast);
            if (rsp_tuser != want.bad_filter)
               report_mismatch("bad_filter", want.bad_filter, rsp_tuser);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int          random_items;
      int          burst;
      bit          force_start;
      logic        start;
      logic [7:0]  raw;
      logic [15:0] new_width;
      depth_type   new_depth;
      directed_plan = '{
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'(FILT_NONE),  1'b1, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'h00FF,        1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b1}},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'(FILT_UP),    1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'h0001,        1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'(FILT_BAD_MAX), 1'b0, 1'b1, ERR_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'h0055,        1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'(FILT_BAD_MIN), 1'b1, 1'b1, ERR_PIXEL},
         '{STEP_CSR,  CSR_IMAGE_WIDTH, 16'd0,           1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'(FILT_SUB),   1'b1, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'h0080,        1'b0, 1'b1, '{8'h80, 1'b1, 1'b0, 1'b1}},
         '{STEP_CSR,  CSR_IMAGE_WIDTH, 16'd3,           1'b0, 1'b0, NO_PIXEL},
         '{STEP_CSR,  CSR_DEPTH_CODE,  16'(DEPTH_1),    1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'(FILT_AVG),   1'b1, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'h00A5,        1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'(FILT_PAETH), 1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'h005A,        1'b0, 1'b0, NO_PIXEL},
         '{STEP_CSR,  CSR_IMAGE_WIDTH, 16'd5,           1'b0, 1'b0, NO_PIXEL},
         '{STEP_CSR,  CSR_DEPTH_CODE,  16'(DEPTH_2),    1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'(FILT_PAETH), 1'b1, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'h003C,        1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'h00C3,        1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'(FILT_SUB),   1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'h000F,        1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'h00F0,        1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'(FILT_PAETH), 1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'h0077,        1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'h0099,        1'b0, 1'b0, NO_PIXEL},
         '{STEP_CSR,  CSR_DEPTH_CODE,  16'(DEPTH_4),    1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'(FILT_NONE),  1'b1, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'h0012,        1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'h0034,        1'b0, 1'b0, NO_PIXEL},
         '{STEP_BYTE, CSR_IMAGE_WIDTH, 16'h00EF,        1'b0, 1'b0, NO_PIXEL}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[s]) begin
         if (directed_plan[s].kind == STEP_CSR) begin
            drain_responses();
            write_csr(directed_plan[s].sel, directed_plan[s].value);
         end else begin
            send_byte(directed_plan[s].value[7:0], directed_plan[s].start);
            if (directed_plan[s].typed) begin
               if (byte_pixels.size() != 1)
                  report_mismatch("directed response count", 1, byte_pixels.size());
               else if (byte_pixels[0] != directed_plan[s].want)
                  report_mismatch("directed response", directed_plan[s].want, byte_pixels[0]);
            end
         end
      end

      // random images; a phase may stop mid-row and the next may resize it
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         drain_responses();
         force_start = 1'b0;
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 9))
               0:       new_width = 16'd0;
               1:       new_width = 16'($urandom_range(0, 65535));
               2, 3:    new_width = 16'($urandom_range(17, 64));
               default: new_width = 16'($urandom_range(1, 16));
            endcase
            new_depth   = depth_type'($urandom_range(DEPTH_1, DEPTH_8));
            force_start = !upper_row_ready(new_width, new_depth);
            write_csr(CSR_IMAGE_WIDTH, new_width);
            write_csr(CSR_DEPTH_CODE, 16'(new_depth));
         end
         force_start |= stream_aborted || ($urandom_range(0, 2) == 0);
         burst = $urandom_range(4, 20);
         for (int n = 0; n < burst; n++) begin
            start = (n == 0 && force_start) || ($urandom_range(0, 49) == 0) ||
                    (stream_aborted && $urandom_range(0, 3) == 0);
            raw = (start || byte_pos == 0) ? pick_filter_byte() : pick_data_byte();
            if (start || !stream_aborted) random_items++;
            send_byte(raw, start);
         end
      end

      drain_responses();
      $display("covered %0d requests, %0d responses (%0d filter errors), %0d register writes",
               n_requests, n_pixels, n_bad, n_csr_writes);
      $display("all filters, all depths, zero and oversized widths, mid-row resizes");
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
